// File: hw/rtl/rotating_slot_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Rotating slot allocator: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ROTATING_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define ROTATING_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define RSA_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define RSA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// Rotating slot allocator package
// Field widths, status and opcode codes shared by the allocator files.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Field widths
  localparam int USER_W      = 16;
  localparam int OFS_W       = 16;
  localparam int IDX_IN_W    = 8;
  localparam int CNT_W       = 5;
  localparam int SLOT_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // Slot table size and reset slot count
  localparam int              DEFAULT_SLOTS = 16;
  localparam logic [CNT_W-1:0] CFG_RESET    = 5'd16;

  // Offset bits retired per cycle of the offset reduction
  localparam int MOD_STEPS = 4;

  // Opcodes
  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RESERVED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

endpackage

// File: hw/rtl/rsa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic [AW-1:0]         rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/rotating_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Rotating slot allocator
// Grants the first free slot from a rotating start point and frees slots.
// ----------------------------------------------------------------------------
// The block keeps SLOTS slots with an occupied bit each and the owning user
// id in a RAM. A word with tuser low reserves: start_offset is reduced modulo
// the slot count four bits a cycle, the free slots are searched from that
// point with wrap, and the grant is written back. A word with tuser high
// releases: the owner is read from the RAM in the accept cycle and the result
// is formed the cycle after. One item is in work at a time; a finished result
// sits in the output register while the next word is accepted. Writing
// cfg_wr_data empties the table at once.
// ----------------------------------------------------------------------------
module rotating_slot_allocator_unit #(
  parameter int SLOTS = rsa_pkg::DEFAULT_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst,
  // slot_count register
  input  logic                              cfg_wr_en,
  input  logic [rsa_pkg::CNT_W-1:0]         cfg_wr_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rsa_pkg::IN_TDATA_W-1:0]    s_tdata,  // user_id, start_offset, slot_index
  input  logic                              s_tuser,  // opcode
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rsa_pkg::OUT_TDATA_W-1:0]   m_tdata,  // slot, owner_id, free_count,
                                                      // has_free, zero pad
  output logic [rsa_pkg::STATUS_W-1:0]      m_tuser   // status
);

  localparam int CW       = rsa_pkg::CNT_W;
  localparam int UW       = rsa_pkg::USER_W;
  localparam int OW       = rsa_pkg::OFS_W;
  localparam int IW       = rsa_pkg::IDX_IN_W;
  localparam int SW       = rsa_pkg::SLOT_W;
  localparam int SLOT_IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MOD_ITER = rsa_pkg::OFS_W / rsa_pkg::MOD_STEPS;
  localparam int MCW      = (MOD_ITER > 1) ? $clog2(MOD_ITER) : 1;
  localparam logic [6:0]    SLOTS_L   = 7'(SLOTS);
  localparam logic [CW-1:0] RESET_EFF =
    (SLOTS < 16) ? CW'(SLOTS) : rsa_pkg::CFG_RESET;

  typedef enum logic [2:0] {IDLE, MOD, SEARCH, REL, OUT} state_t;

  state_t                       state;
  logic [CW-1:0]                slot_cfg;
  logic [CW-1:0]                eff_n;
  logic [SLOTS-1:0]             occ;
  logic [CW-1:0]                free_slots;

  logic [UW-1:0]                user_q;
  logic [OW-1:0]                ofs_sh;
  logic [IW-1:0]                idx_q;
  logic [CW-1:0]                rem;
  logic [MCW-1:0]               mod_cnt;

  logic [rsa_pkg::STATUS_W-1:0] res_status;
  logic [SW-1:0]                res_slot;
  logic [UW-1:0]                res_owner;

  logic [CW-1:0]                rem_next;
  logic [OW-1:0]                ofs_next;
  logic [CW:0]                  mod_t;

  logic [SLOTS-1:0]             free_vec;
  logic                         found_hi;
  logic                         found_lo;
  logic [7:0]                   k_hi;
  logic [7:0]                   k_lo;
  logic                         found;
  logic [7:0]                   k_sel;
  logic                         rel_hit;

  logic                         ram_we;
  logic [SLOT_IW-1:0]           ram_rd_addr;
  logic [UW-1:0]                ram_rd_data;

  // Clamp a slot_count value to 1..SLOTS
  function automatic logic [CW-1:0] eff_of(input logic [CW-1:0] d);
    logic [CW-1:0] r;
    r = d;
    if (d == '0) begin
      r = CW'(1);
    end else if ({2'b00, d} > SLOTS_L) begin
      r = SLOTS_L[CW-1:0];
    end
    return r;
  endfunction

  assign eff_n    = eff_of(slot_cfg);
  assign s_tready = (state == IDLE);

  // Offset reduction: retire MOD_STEPS offset bits into the remainder
  always_comb begin
    rem_next = rem;
    ofs_next = ofs_sh;
    mod_t    = '0;
    for (int j = 0; j < rsa_pkg::MOD_STEPS; j++) begin
      mod_t    = {rem_next, ofs_next[OW-1]};
      ofs_next = {ofs_next[OW-2:0], 1'b0};
      if (mod_t >= {1'b0, eff_n}) begin
        mod_t = mod_t - {1'b0, eff_n};
      end
      rem_next = mod_t[CW-1:0];
    end
  end

  // Rotating first-free search: lowest free slot at or after the start,
  // else lowest free slot overall
  always_comb begin
    found_hi = 1'b0;
    found_lo = 1'b0;
    k_hi     = '0;
    k_lo     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = !occ[i] && (7'(i) < {2'b00, eff_n});
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found_lo = 1'b1;
        k_lo     = 8'(i);
        if (7'(i) >= {2'b00, rem}) begin
          found_hi = 1'b1;
          k_hi     = 8'(i);
        end
      end
    end
    found = found_lo;
    k_sel = found_hi ? k_hi : k_lo;
  end

  // Release hit: index in use and slot occupied
  assign rel_hit = (idx_q < {3'b000, eff_n}) && occ[idx_q[SLOT_IW-1:0]];

  // Owner table: read on release accept, written on grant
  assign ram_we      = (state == SEARCH) && found;
  assign ram_rd_addr = s_tdata[UW+OW +: SLOT_IW];

  rsa_ram #(
    .WIDTH (UW),
    .DEPTH (SLOTS)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (k_sel[SLOT_IW-1:0]),
    .wr_data (user_q),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer, table state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      slot_cfg   <= rsa_pkg::CFG_RESET;
      occ        <= '0;
      free_slots <= RESET_EFF;
      m_tvalid   <= 1'b0;
    end else begin
      // Drop the result once taken, unless the next one loads this cycle
      if (m_tvalid && m_tready && (state != OUT)) begin
        m_tvalid <= 1'b0;
      end

      // Register write empties the table
      if (cfg_wr_en) begin
        slot_cfg   <= cfg_wr_data;
        occ        <= '0;
        free_slots <= eff_of(cfg_wr_data);
      end

      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            user_q  <= s_tdata[UW-1:0];
            ofs_sh  <= s_tdata[UW +: OW];
            idx_q   <= s_tdata[UW+OW +: IW];
            rem     <= '0;
            mod_cnt <= '0;
            state   <= (s_tuser == rsa_pkg::OP_RELEASE) ? REL : MOD;
          end
        end
        MOD: begin
          rem     <= rem_next;
          ofs_sh  <= ofs_next;
          mod_cnt <= mod_cnt + MCW'(1);
          if (mod_cnt == MCW'(MOD_ITER - 1)) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          if (found) begin
            occ[k_sel[SLOT_IW-1:0]] <= 1'b1;
            if (free_slots != '0) begin
              free_slots <= free_slots - CW'(1);
            end
            res_status <= rsa_pkg::ST_RESERVED;
            res_slot   <= k_sel[SW-1:0];
            res_owner  <= user_q;
          end else begin
            res_status <= rsa_pkg::ST_FULL;
            res_slot   <= '0;
            res_owner  <= '0;
          end
          state <= OUT;
        end
        REL: begin
          if (rel_hit) begin
            occ[idx_q[SLOT_IW-1:0]] <= 1'b0;
            if (free_slots < eff_n) begin
              free_slots <= free_slots + CW'(1);
            end
            res_status <= rsa_pkg::ST_RELEASED;
            res_slot   <= idx_q[SW-1:0];
            res_owner  <= ram_rd_data;
          end else begin
            res_status <= rsa_pkg::ST_IGNORED;
            res_slot   <= '0;
            res_owner  <= '0;
          end
          state <= OUT;
        end
        OUT: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {6'b000000, (free_slots != '0), free_slots, res_owner, res_slot};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/rsa_checker.sv
// ----------------------------------------------------------------------------
// Rotating slot allocator checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotating_slot_allocator_unit_defines.svh"

module rsa_checker #(
  parameter int SLOTS = rsa_pkg::DEFAULT_SLOTS
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rsa_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [rsa_pkg::STATUS_W-1:0]    m_tuser
);

  localparam logic [6:0] SLOTS_L = 7'(SLOTS);

  // has_free mirrors a nonzero free count
  `RSA_ASSERT_IMPLIES(a_has_free, clk, rst, m_tvalid, m_tdata[25] == (m_tdata[24:20] != 5'd0), "has_free disagrees with free_count")

  // A full result carries no slot, no owner and no free slot
  `RSA_ASSERT_IMPLIES(a_full_empty, clk, rst, m_tvalid && (m_tuser == rsa_pkg::ST_FULL), m_tdata[25:0] == 26'd0, "full result with nonzero fields")

  // An ignored release carries no slot and no owner
  `RSA_ASSERT_IMPLIES(a_ignored_zero, clk, rst, m_tvalid && (m_tuser == rsa_pkg::ST_IGNORED), m_tdata[19:0] == 20'd0, "ignored release with nonzero slot or owner")

  // Free count never exceeds the table size
  `RSA_ASSERT_IMPLIES(a_free_bound, clk, rst, m_tvalid, {2'b00, m_tdata[24:20]} <= SLOTS_L, "free_count above table size")

  // A stalled result holds
  `RSA_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind rotating_slot_allocator_unit rsa_checker #(
  .SLOTS (SLOTS)
) u_rsa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
